[rtl/linear_probe_slot_map_macros.svh]
// Assertion macros used by the checker file of the slot map.
`ifndef LINEAR_PROBE_SLOT_MAP_MACROS_SVH
`define LINEAR_PROBE_SLOT_MAP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define LPSM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define LPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpsm_pkg.sv]
// Package with the types, widths and codes of the linear probing slot map.
`default_nettype none
package lpsm_pkg;

    localparam int KEY_W         = 32;
    localparam int SLOT_W        = 12;
    localparam int COUNT_W       = 13;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int SLOT_CAPACITY = 4096;
    localparam int TABLE_SIZE_DEF = 4096;
    localparam int MAX_RESET     = 4096;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd5;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } entry_t;

endpackage
`default_nettype wire

[rtl/lpsm_table.sv]
// Single-port-write, registered-read memory holding the key and slot of every entry.
`default_nettype none
module lpsm_table #(
    parameter int DEPTH  = lpsm_pkg::TABLE_SIZE_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                   clk,
    input  wire                   wr_en,
    input  wire [ADDR_W-1:0]      wr_addr,
    input  lpsm_pkg::entry_t      wr_data,
    input  wire [ADDR_W-1:0]      rd_addr,
    output lpsm_pkg::entry_t      rd_data
);

    lpsm_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[rtl/linear_probe_slot_map.sv]
// Top level of the linear probing hash map from nonzero keys to dense slot numbers.
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   tuser: kind; tdata: key
//  m_*       out        m_tvalid/m_tready   tuser: status; tdata: slot, used_count
//  cfg_*     in         cfg_wen             cfg_wdata: max_entries
//
// A lookup or insert makes one or more probes; each probe is one table read and one compare.
// Invalid requests go straight to ST_FINISH; a clear sweeps every table entry before its result.
// After reset every table entry is cleared while s_tready stays low.
// A new word is taken while a result waits in the output register; a second result
// waits in the sequencer until the first one is taken.
`default_nettype none
module linear_probe_slot_map #(
    parameter int TABLE_SIZE = lpsm_pkg::TABLE_SIZE_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] key
    input  wire  [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [11:0] slot, [24:12] used_count, [31:25] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  wire         cfg_wen,
    input  wire  [12:0] cfg_wdata  // [12:0] max_entries
);

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam int COUNT_W = lpsm_pkg::COUNT_W;
    localparam int SLOT_W  = lpsm_pkg::SLOT_W;
    localparam int KEY_W   = lpsm_pkg::KEY_W;
    localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(lpsm_pkg::SLOT_CAPACITY);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                clr_addr_reg, clr_addr_next;
    logic                            clr_report_reg, clr_report_next;
    logic [COUNT_W-1:0]              used_reg, used_next;
    logic [COUNT_W-1:0]              max_reg;
    logic                            m_valid_reg, m_valid_next;

    logic                            insert_reg, insert_next;
    logic [KEY_W-1:0]                key_reg, key_next;
    logic [IDX_W-1:0]                pos_reg, pos_next;
    logic [IDX_W-1:0]                cnt_reg, cnt_next;
    logic [lpsm_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]               res_slot_reg, res_slot_next;
    logic [lpsm_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [SLOT_W-1:0]               m_slot_reg, m_slot_next;
    logic [COUNT_W-1:0]              m_used_reg, m_used_next;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    lpsm_pkg::entry_t                wr_data;
    lpsm_pkg::entry_t                rd_data;

    logic                            hit;
    logic                            empty;
    logic                            room;
    logic [COUNT_W-1:0]              limit;
    logic                            load_out;

    lpsm_table #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    assign hit   = (rd_data.key == key_reg);
    assign empty = (rd_data.key == '0);
    assign limit = (max_reg < CAPACITY) ? max_reg : CAPACITY;
    assign room  = (used_reg < limit);

    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        used_next       = used_reg;
        insert_next     = insert_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data.slot    = used_reg[SLOT_W-1:0];
        wr_data.key     = key_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data.slot  = '0;
                wr_data.key   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    clr_addr_next   = '0;
                    clr_report_next = 1'b0;
                    res_status_next = lpsm_pkg::STATUS_INVALID;
                    res_slot_next   = '0;
                    state_next      = clr_report_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next        = s_tdata;
                    insert_next     = (s_tuser == lpsm_pkg::KIND_INSERT);
                    pos_next        = IDX_W'(s_tdata & 32'(TABLE_SIZE - 1));
                    cnt_next        = '0;
                    res_status_next = lpsm_pkg::STATUS_INVALID;
                    res_slot_next   = '0;
                    if (s_tuser == lpsm_pkg::KIND_CLEAR)
                    begin
                        used_next       = '0;
                        clr_report_next = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    else if ((s_tuser == lpsm_pkg::KIND_LOOKUP ||
                              s_tuser == lpsm_pkg::KIND_INSERT) && s_tdata != '0)
                    begin
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PROBE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                res_slot_next = '0;
                if (hit)
                begin
                    res_status_next = lpsm_pkg::STATUS_FOUND;
                    res_slot_next   = rd_data.slot;
                    state_next      = ST_FINISH;
                end
                else if (empty)
                begin
                    state_next = ST_FINISH;
                    if (!insert_reg)
                    begin
                        res_status_next = lpsm_pkg::STATUS_NOT_FOUND;
                    end
                    else if (room)
                    begin
                        wr_en           = 1'b1;
                        used_next       = used_reg + 1'b1;
                        res_status_next = lpsm_pkg::STATUS_INSERTED;
                        res_slot_next   = used_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        res_status_next = lpsm_pkg::STATUS_NO_ROOM;
                    end
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    res_status_next = lpsm_pkg::STATUS_FULL;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_used_next   = m_used_reg;
        if (load_out)
        begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_slot_next   = res_slot_reg;
            m_used_next   = used_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            used_reg       <= '0;
            max_reg        <= COUNT_W'(lpsm_pkg::MAX_RESET);
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            used_reg       <= used_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wen)
            begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        insert_reg     <= insert_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_used_reg     <= m_used_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_used_reg, m_slot_reg};

endmodule
`default_nettype wire

[rtl/lpsm_checker.sv]
// Port-level checker for the slot map, bound to the top level.
`default_nettype none
`include "linear_probe_slot_map_macros.svh"
module lpsm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [2:0]  m_tuser
);

    `LPSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Result word changed while stalled")
    `LPSM_ASSERT_SAME(a_status_range, m_tvalid, m_tuser <= lpsm_pkg::STATUS_INVALID, "Result status out of range")
    `LPSM_ASSERT_SAME(a_slot_zero, m_tvalid && m_tuser != lpsm_pkg::STATUS_FOUND && m_tuser != lpsm_pkg::STATUS_INSERTED, m_tdata[11:0] == 12'd0, "Slot not zero for a failed request")
    `LPSM_ASSERT_SAME(a_insert_count, m_tvalid && m_tuser == lpsm_pkg::STATUS_INSERTED, m_tdata[24:12] == {1'b0, m_tdata[11:0]} + 13'd1, "Used count does not follow the inserted slot")

endmodule

bind linear_probe_slot_map lpsm_checker u_lpsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
